FILE: rtl/scl_pkg.sv
// Package for the serial command line parser: constants, types and decode functions.
`timescale 1ns / 1ps

package scl_pkg;

  // Width of the decimal accumulator; the value field is always 32 bits.
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned VALUE_OUT_BITS = 32;
  localparam int unsigned WIDE_BITS =
      (VALUE_BITS > VALUE_OUT_BITS) ? VALUE_BITS : VALUE_OUT_BITS;
  localparam int unsigned POS_BITS = 5;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Packed result width: command and value, filled up to whole bytes.
  localparam int unsigned CMD_BITS = 4;
  localparam int unsigned RES_BITS = CMD_BITS + VALUE_OUT_BITS;
  localparam int unsigned RES_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

  // Character codes.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_JV = 4'd0,
    CMD_AC = 4'd1,
    CMD_DC = 4'd2,
    CMD_SP = 4'd3,
    CMD_PA = 4'd4,
    CMD_PR = 4'd5,
    CMD_BAD_WRITE = 4'd6,
    CMD_VX = 4'd7,
    CMD_PX = 4'd8,
    CMD_IQ = 4'd9,
    CMD_BAD_READ = 4'd10
  } cmd_e;

  // One result leaving the parser core.
  typedef struct packed {
    logic produce;
    cmd_e command;
    logic signed [VALUE_OUT_BITS-1:0] value;
  } result_t;

  // Command code of a write line from its two letters.
  function automatic cmd_e write_code(input logic [15:0] letters);
    cmd_e code;
    unique case (letters)
      "JV": code = CMD_JV;
      "AC": code = CMD_AC;
      "DC": code = CMD_DC;
      "SP": code = CMD_SP;
      "PA": code = CMD_PA;
      "PR": code = CMD_PR;
      default: code = CMD_BAD_WRITE;
    endcase
    return code;
  endfunction

  // Command code of a read line from its two letters.
  function automatic cmd_e read_code(input logic [15:0] letters);
    cmd_e code;
    unique case (letters)
      "VX": code = CMD_VX;
      "PX": code = CMD_PX;
      "IQ": code = CMD_IQ;
      default: code = CMD_BAD_READ;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/scl_core.sv
// Line state of the parser and the decode of one character into an optional result.
`timescale 1ns / 1ps

module scl_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  output scl_pkg::result_t    result_o
);
  import scl_pkg::*;

  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [7:0]            first_q, first_d;
  logic [7:0]            second_q, second_d;
  logic                  equals_q, equals_d;
  logic                  minus_q, minus_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  logic                  is_space;
  logic                  is_term;
  logic [7:0]            second_eff;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] value_v;
  logic [WIDE_BITS-1:0]  value_wide;

  assign is_space = (rx_byte_i == CHAR_SPACE);
  assign is_term  = (rx_byte_i == CHAR_LF) || (rx_byte_i == CHAR_CR) ||
                    (rx_byte_i == CHAR_SEMI);

  // A terminator in the second place stands in as the second letter.
  assign second_eff = (pos_q == POS_BITS'(1)) ? rx_byte_i : second_q;

  // Accumulator step: times ten by shift and add, then the code minus '0'.
  assign acc_next = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(rx_byte_i) -
                    VALUE_BITS'(CHAR_ZERO);

  // Signed operand, wrapped to the accumulator width, then its low 32 bits.
  assign value_v    = minus_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
  assign value_wide = WIDE_BITS'(value_v);

  // Result of a terminator on a line that is not empty. The flag says whether the
  // presented character would give a result; the caller decides when it is taken.
  always_comb begin
    result_o.produce = !is_space && is_term && (pos_q != '0);
    if (equals_q) begin
      result_o.command = write_code({first_q, second_eff});
      result_o.value   = value_wide[VALUE_OUT_BITS-1:0];
    end else begin
      result_o.command = read_code({first_q, second_eff});
      result_o.value   = '0;
    end
  end

  // Next line state.
  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    equals_d = equals_q;
    minus_d  = minus_q;
    acc_d    = acc_q;
    if (step_i && !is_space) begin
      if (is_term) begin
        pos_d    = '0;
        first_d  = '0;
        second_d = '0;
        equals_d = 1'b0;
        minus_d  = 1'b0;
        acc_d    = '0;
      end else begin
        priority if (pos_q == POS_BITS'(0)) begin
          first_d = rx_byte_i;
        end else if (pos_q == POS_BITS'(1)) begin
          second_d = rx_byte_i;
        end else if (pos_q == POS_BITS'(2)) begin
          equals_d = (rx_byte_i == CHAR_EQUALS);
        end else if ((pos_q == POS_BITS'(3)) && (rx_byte_i == CHAR_MINUS)) begin
          minus_d = 1'b1;
        end else begin
          acc_d = acc_next;
        end
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_BITS'(1);
        end
      end
    end
  end

  // State registers; all cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      equals_q <= 1'b0;
      minus_q  <= 1'b0;
      acc_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      equals_q <= equals_d;
      minus_q  <= minus_d;
      acc_q    <= acc_d;
    end
  end

endmodule

FILE: rtl/scl_out_stage.sv
// Result register on the master side of the parser.
`timescale 1ns / 1ps

module scl_out_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  scl_pkg::result_t                     result_i,
  output logic                                 can_load_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [scl_pkg::RES_TDATA_BITS-1:0]   m_axis_tdata
);
  import scl_pkg::*;

  logic                      valid_q, valid_d;
  logic [RES_TDATA_BITS-1:0] data_q, data_d;

  // The register can take a new item when empty or when its item leaves.
  assign can_load_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = RES_TDATA_BITS'({result_i.value, result_i.command});
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

FILE: rtl/serial_command_line_parser.sv
// Top level of the serial command line parser: input register, parser core, result register.
// A byte accepted into the input register is decoded in the following cycle; a result
// then passes through the result register. Throughput: one byte per cycle unless a line
// end stalls, with one multiply-by-ten and add from the input register to the accumulator.
// A byte ending a line stalls only while the result register is full and not taken. Reset
// is asynchronous and active low; it empties both registers and clears the line.
`timescale 1ns / 1ps

module serial_command_line_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [scl_pkg::RES_TDATA_BITS-1:0] m_axis_tdata   // [3:0] command, [35:4] value, zero pad
);
  import scl_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       advance;
  logic       out_can_load;
  result_t    result;

  // Input register: moves on whenever its byte can be decoded.
  assign advance       = in_valid_q && (!result.produce || out_can_load);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_byte_d  = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  // Line state and decode.
  scl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  // Result register.
  scl_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_valid_q && result.produce && out_can_load),
    .result_i      (result),
    .can_load_o    (out_can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: rtl/scl_checker.sv
// Port-level checks of the serial command line parser and their binding to the top level.
`timescale 1ns / 1ps

module scl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [7:0]                         s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [scl_pkg::RES_TDATA_BITS-1:0] m_axis_tdata
);
  import scl_pkg::*;

  // A result that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Only defined command codes are shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CMD_BITS-1:0] <= CMD_BAD_READ)
    else $error("undefined command code");

  // Read commands carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[CMD_BITS-1:0] >= CMD_VX) |->
      m_axis_tdata[RES_BITS-1:CMD_BITS] == '0)
    else $error("read command with a value");

  // With the result register empty, the block always takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

  // An item offered and not yet taken is held unchanged by the sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("offered item changed before acceptance");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
